// File: design/rdc_pkg.sv
// rdc_pkg: shared types and constants for the ring deque with search
// holds the action codes and the control bundle broadcast to the slot cells
// no dependencies
package rdc_pkg;

  localparam int VALUE_W     = 32;
  localparam int ACTION_W    = 3;
  localparam int RING_W      = 5;
  localparam int RING_MIN    = 2;
  localparam int RING_MAX    = 16;
  localparam int RING_RESET  = 16;

  // action codes carried by an input beat
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4,
    ACT_VISIT      = 3'd5
  } action_t;

  // control shared by every cell in the row
  typedef struct packed {
    logic               load;     // place the walk token at the start slot
    logic               step;     // hand the token one cell along
    logic [VALUE_W-1:0] key;      // search target
    logic [VALUE_W-1:0] wr_data;  // value for a push
  } cell_ctl_t;

endpackage

// File: design/ring_deque_with_search_core.sv
// ring_deque_with_search_core: double-ended queue in a ring of slot cells
// with front-to-back search and visit walks; depends on rdc_pkg and rdc_cell
//
//   port group  dir  handshake            payload
//   in_         in   in_valid/in_ready    in_action, in_value
//   out_        out  out_valid/out_ready  out_ok, out_element, out_last
//   cfg_        in   cfg_wr_en            cfg_wr_data (ring_size)
//
// push, pop and unused actions give one beat each.
// search and visit place the token at the front slot, then walk it over each stored entry
// (up to ring_size-1), the token moving one cell per cycle; a
// search stops at its first hit, and an empty ring gives a single beat.
// a walk pauses while the output register holds a beat not yet taken.
// reset (rst_n low at a clock edge) empties the deque and sets ring_size to 16.
module ring_deque_with_search_core #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rdc_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [rdc_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic signed [rdc_pkg::VALUE_W-1:0]  out_element,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [rdc_pkg::RING_W-1:0]          cfg_wr_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (IW + 1 > rdc_pkg::RING_W) ? IW + 1 : rdc_pkg::RING_W;

  typedef enum logic [0:0] {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                       state_r, state_nxt;
  logic [rdc_pkg::RING_W-1:0]   ring_size_r, ring_size_nxt;
  logic [IW-1:0]                front_r, front_nxt;
  logic [IW-1:0]                back_r, back_nxt;
  logic [IW-1:0]                pos_r, pos_nxt;
  logic                         visit_r, visit_nxt;
  logic [rdc_pkg::VALUE_W-1:0]  key_r, key_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ok_r, out_ok_nxt;
  logic [rdc_pkg::VALUE_W-1:0]  out_element_r, out_element_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [CW-1:0]                slots;
  logic [IW-1:0]                last_slot;
  logic                         empty, full, accept, out_free;
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  logic [IW-1:0]                pos_next;
  logic                         at_end;
  rdc_pkg::cell_ctl_t           ctl;
  logic [DEPTH-1:0]             tok_w, tok_in_w, hit_w;
  logic [rdc_pkg::VALUE_W-1:0]  rd_w [DEPTH];
  logic [rdc_pkg::VALUE_W-1:0]  rd_bus;
  logic                         hit_any;

  function automatic logic [IW-1:0] slot_next(logic [IW-1:0] i, logic [IW-1:0] lim);
    return (i == lim) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] slot_prev(logic [IW-1:0] i, logic [IW-1:0] lim);
    return (i == '0) ? lim : i - 1'b1;
  endfunction

  // slots in use: register saturated to the legal range and to DEPTH
  always_comb begin
    if (ring_size_r < rdc_pkg::RING_W'(rdc_pkg::RING_MIN)) begin
      slots = CW'(rdc_pkg::RING_MIN);
    end else if (ring_size_r > rdc_pkg::RING_W'(rdc_pkg::RING_MAX)) begin
      slots = CW'(rdc_pkg::RING_MAX);
    end else begin
      slots = CW'(ring_size_r);
    end
    if (slots > CW'(DEPTH)) begin
      slots = CW'(DEPTH);
    end
  end

  assign last_slot = IW'(slots - 1'b1);
  assign empty     = (front_r == back_r);
  assign full      = (front_r == slot_next(back_r, last_slot));
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign pos_next  = slot_next(pos_r, last_slot);
  assign at_end    = (pos_next == back_r);

  // row of slot cells with the token ring closed at the last slot in use
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in_w[i] = tok_w[last_slot];
    end else begin : g_body
      assign tok_in_w[i] = tok_w[i-1] && (IW'(i-1) != last_slot);
    end

    rdc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .wr_en_i     (wr_en && (wr_addr == IW'(i))),
      .tok_start_i (front_r == IW'(i)),
      .tok_i       (tok_in_w[i]),
      .tok_o       (tok_w[i]),
      .hit_o       (hit_w[i]),
      .rd_o        (rd_w[i])
    );
  end

  // collect the token holder's value and compare
  always_comb begin
    rd_bus  = '0;
    hit_any = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus  = rd_bus | rd_w[i];
      hit_any = hit_any | hit_w[i];
    end
  end

  // control: single-beat actions, walk sequencing, config writes
  always_comb begin
    state_nxt       = state_r;
    ring_size_nxt   = ring_size_r;
    front_nxt       = front_r;
    back_nxt        = back_r;
    pos_nxt         = pos_r;
    visit_nxt       = visit_r;
    key_nxt         = key_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_ok_nxt      = out_ok_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = back_r;
    ctl.load        = 1'b0;
    ctl.step        = 1'b0;
    ctl.key         = key_r;
    ctl.wr_data     = in_value;

    if (accept) begin
      out_ok_nxt      = 1'b0;
      out_element_nxt = '0;
      out_last_nxt    = 1'b1;
      out_valid_nxt   = 1'b1;
      case (rdc_pkg::action_t'(in_action))
        rdc_pkg::ACT_PUSH_FRONT: begin
          if (!full) begin
            front_nxt  = slot_prev(front_r, last_slot);
            wr_addr    = front_nxt;
            wr_en      = 1'b1;
            out_ok_nxt = 1'b1;
          end
        end
        rdc_pkg::ACT_PUSH_BACK: begin
          if (!full) begin
            wr_addr    = back_r;
            wr_en      = 1'b1;
            back_nxt   = slot_next(back_r, last_slot);
            out_ok_nxt = 1'b1;
          end
        end
        rdc_pkg::ACT_POP_FRONT: begin
          if (!empty) begin
            front_nxt  = slot_next(front_r, last_slot);
            out_ok_nxt = 1'b1;
          end
        end
        rdc_pkg::ACT_POP_BACK: begin
          if (!empty) begin
            back_nxt   = slot_prev(back_r, last_slot);
            out_ok_nxt = 1'b1;
          end
        end
        rdc_pkg::ACT_SEARCH, rdc_pkg::ACT_VISIT: begin
          if (!empty) begin
            out_valid_nxt = 1'b0;
            key_nxt       = in_value;
            ctl.load      = 1'b1;
            pos_nxt       = front_r;
            visit_nxt     = (rdc_pkg::action_t'(in_action) == rdc_pkg::ACT_VISIT);
            state_nxt     = S_WALK;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == S_WALK && out_free) begin
      if (visit_r) begin
        out_valid_nxt   = 1'b1;
        out_ok_nxt      = 1'b1;
        out_element_nxt = rd_bus;
        out_last_nxt    = at_end;
      end else if (hit_any || at_end) begin
        out_valid_nxt   = 1'b1;
        out_ok_nxt      = hit_any;
        out_element_nxt = '0;
        out_last_nxt    = 1'b1;
      end
      if (at_end || (!visit_r && hit_any)) begin
        state_nxt = S_IDLE;
      end else begin
        ctl.step = 1'b1;
        pos_nxt  = pos_next;
      end
    end

    // ring size write empties the deque
    if (cfg_wr_en) begin
      ring_size_nxt = cfg_wr_data;
      front_nxt     = '0;
      back_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    pos_r         <= pos_nxt;
    visit_r       <= visit_nxt;
    out_ok_r      <= out_ok_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_size_r <= rdc_pkg::RING_W'(rdc_pkg::RING_RESET);
      front_r     <= '0;
      back_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_size_r <= ring_size_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  // exactly one cell holds the token while walking
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> $onehot(tok_w))
    else $error("walk token not one-hot");

  // token position tracker agrees with the cell row
  a_tok_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> tok_w[pos_r])
    else $error("walk position out of step with token");

  // indices stay inside the slots in use
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(front_r) < slots) && (CW'(back_r) < slots))
    else $error("ring index beyond slots in use");

  // a failed result never carries an element and is always last
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_element_r == '0 && out_last_r)
    else $error("failed beat carries data or is not last");
`endif

endmodule

// File: design/rdc_cell.sv
// rdc_cell: one ring slot, holding its stored value and the walk token bit
// the token arrives from the neighbor cell and is passed on each step
// depends on rdc_pkg
module rdc_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rdc_pkg::cell_ctl_t                 ctl_i,
  input  logic                               wr_en_i,
  input  logic                               tok_start_i,
  input  logic                               tok_i,
  output logic                               tok_o,
  output logic                               hit_o,
  output logic [rdc_pkg::VALUE_W-1:0]        rd_o
);

  logic [rdc_pkg::VALUE_W-1:0] data_r;
  logic                        tok_r;
  logic                        tok_nxt;

  // slot storage, written only by a push aimed here
  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      data_r <= ctl_i.wr_data;
    end
  end

  // token placement and hand-off
  always_comb begin
    tok_nxt = tok_r;
    if (ctl_i.load) begin
      tok_nxt = tok_start_i;
    end else if (ctl_i.step) begin
      tok_nxt = tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // local compare and gated read onto the shared bus
  assign tok_o = tok_r;
  assign hit_o = tok_r && (data_r == ctl_i.key);
  assign rd_o  = tok_r ? data_r : '0;

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for ring_deque_with_search_core (push, pop, search, visit)
// keeps its own deque predictor in a scoreboard class and drives random gaps and stalls
// depends on rdc_pkg and the ring_deque_with_search_core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOT_DEPTH   = 16;
  localparam int          LIMIT_CYCLES = 400000;
  localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;

  // one expected result beat
  typedef struct packed {
    logic                        ok;
    logic [rdc_pkg::VALUE_W-1:0] element;
    logic                        last;
  } result_beat_t;

  // deque predictor plus queue of result beats still owed by the block
  class deque_scoreboard;
    logic [rdc_pkg::VALUE_W-1:0] slot_val [SLOT_DEPTH];
    int unsigned                 head;
    int unsigned                 tail;
    int unsigned                 slots;
    result_beat_t                owed_beats [$];
    int                          errors;

    function new();
      foreach (slot_val[i]) slot_val[i] = '0;
      head   = 0;
      tail   = 0;
      slots  = rdc_pkg::RING_RESET;
      errors = 0;
    endfunction

    // ring size saturates to 2..16 and to the store depth; any write empties the deque
    function void set_ring(logic [rdc_pkg::RING_W-1:0] v);
      slots = v;
      if (slots < rdc_pkg::RING_MIN) slots = rdc_pkg::RING_MIN;
      if (slots > rdc_pkg::RING_MAX) slots = rdc_pkg::RING_MAX;
      if (slots > SLOT_DEPTH) slots = SLOT_DEPTH;
      head = 0;
      tail = 0;
    endfunction

    function int unsigned step_fwd(int unsigned i);
      return (i + 1 >= slots) ? 0 : i + 1;
    endfunction

    function int unsigned step_back(int unsigned i);
      return (i == 0) ? slots - 1 : i - 1;
    endfunction

    function void owe(logic ok, logic [rdc_pkg::VALUE_W-1:0] element, logic last);
      result_beat_t b;
      b.ok      = ok;
      b.element = element;
      b.last    = last;
      owed_beats.push_back(b);
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    // update the deque for one accepted input beat and queue its results
    function void note_input(logic [rdc_pkg::ACTION_W-1:0] code,
                             logic [rdc_pkg::VALUE_W-1:0] v);
      bit          is_empty;
      bit          is_full;
      logic        ok;
      int unsigned p;
      int unsigned q;
      is_empty = (head == tail);
      is_full  = (head == step_fwd(tail));
      ok       = 1'b0;
      case (code)
        rdc_pkg::ACT_PUSH_FRONT: begin
          if (!is_full) begin
            head = step_back(head);
            slot_val[head] = v;
            ok = 1'b1;
          end
        end
        rdc_pkg::ACT_PUSH_BACK: begin
          if (!is_full) begin
            slot_val[tail] = v;
            tail = step_fwd(tail);
            ok = 1'b1;
          end
        end
        rdc_pkg::ACT_POP_FRONT: begin
          if (!is_empty) begin
            head = step_fwd(head);
            ok = 1'b1;
          end
        end
        rdc_pkg::ACT_POP_BACK: begin
          if (!is_empty) begin
            tail = step_back(tail);
            ok = 1'b1;
          end
        end
        rdc_pkg::ACT_SEARCH: begin
          p = head;
          while (p != tail) begin
            if (slot_val[p] == v) begin
              ok = 1'b1;
              break;
            end
            p = step_fwd(p);
          end
        end
        rdc_pkg::ACT_VISIT: begin
          if (is_empty) begin
            owe(1'b0, '0, 1'b1);
          end else begin
            p = head;
            while (p != tail) begin
              q = step_fwd(p);
              owe(1'b1, slot_val[p], q == tail);
              p = q;
            end
          end
          return;
        end
        default: ;
      endcase
      owe(ok, '0, 1'b1);
    endfunction

    // compare one accepted output beat against the oldest owed beat
    function void check_result(logic ok, logic [rdc_pkg::VALUE_W-1:0] element, logic last);
      result_beat_t b;
      if (owed_beats.size() == 0) begin
        $error("unexpected result beat: ok=%0d element=%0d last=%0d",
               ok, $signed(element), last);
        errors++;
        return;
      end
      b = owed_beats.pop_front();
      if (ok !== b.ok) begin
        $error("ok mismatch: expected %0d, got %0d", b.ok, ok);
        errors++;
      end
      if (element !== b.element) begin
        $error("element mismatch: expected %0d, got %0d",
               $signed(b.element), $signed(element));
        errors++;
      end
      if (last !== b.last) begin
        $error("last mismatch: expected %0d, got %0d", b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [rdc_pkg::ACTION_W-1:0] in_action;
  logic [rdc_pkg::VALUE_W-1:0]  in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_ok;
  logic [rdc_pkg::VALUE_W-1:0]  out_element;
  logic                         out_last;
  logic                         cfg_wr_en;
  logic [rdc_pkg::RING_W-1:0]   cfg_wr_data;

  deque_scoreboard              sb = new();
  logic [rdc_pkg::VALUE_W-1:0]  value_pool [8];
  bit                           calm;

  ring_deque_with_search_core #(.DEPTH(SLOT_DEPTH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_element (out_element),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // values mostly from a small pool so searches hit
  function automatic logic [rdc_pkg::VALUE_W-1:0] pool_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // action mix; push_pct steers between filling and draining
  function automatic logic [rdc_pkg::ACTION_W-1:0] random_action(int push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return rdc_pkg::ACT_SEARCH;
    if (r < 20) return rdc_pkg::ACT_VISIT;
    if (r < 22) return $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? rdc_pkg::ACT_PUSH_BACK : rdc_pkg::ACT_PUSH_FRONT;
    return $urandom_range(0, 1) ? rdc_pkg::ACT_POP_BACK : rdc_pkg::ACT_POP_FRONT;
  endfunction

  // result side: random stalls on out_ready
  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      hold = idle_len();
      if (hold == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_ok, out_element, out_last);
  end

  // one input beat; called right after a posedge, returns at its acceptance edge
  task automatic drive_action(input logic [rdc_pkg::ACTION_W-1:0] code,
                              input logic [rdc_pkg::VALUE_W-1:0] v);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= code;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(code, v);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // ring size write, only with the block idle
  task automatic write_ring_size(input logic [rdc_pkg::RING_W-1:0] v);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_ring(v);
  endtask

  // first half leans toward fill_pct pushes, second half drains
  task automatic run_random(input int count, input int fill_pct);
    int i;
    for (i = 0; i < count; i++)
      drive_action(random_action(i < count / 2 ? fill_pct : 100 - fill_pct), pool_value());
  endtask

  // stimulus
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = rdc_pkg::ACT_PUSH_FRONT;
    in_value    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7fff_ffff;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: empty ring, unused codes, extreme values, search hit and miss
    drive_action(rdc_pkg::ACT_VISIT, 32'h0);
    drive_action(rdc_pkg::ACT_POP_FRONT, 32'h0);
    drive_action(rdc_pkg::ACT_POP_BACK, 32'h0);
    drive_action(rdc_pkg::ACT_SEARCH, 32'h0);
    drive_action(ACT_SPARE_LO, 32'h5555_5555);
    drive_action(ACT_SPARE_HI, 32'haaaa_aaaa);
    drive_action(rdc_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
    drive_action(rdc_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    drive_action(rdc_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
    drive_action(rdc_pkg::ACT_PUSH_BACK, 32'hffff_ffff);
    drive_action(rdc_pkg::ACT_SEARCH, 32'h8000_0000);
    drive_action(rdc_pkg::ACT_SEARCH, 32'h1234_5678);
    drive_action(rdc_pkg::ACT_VISIT, 32'h0);
    drive_action(rdc_pkg::ACT_POP_BACK, 32'h0);
    drive_action(rdc_pkg::ACT_POP_FRONT, 32'h0);
    drive_action(rdc_pkg::ACT_VISIT, 32'h0);

    // directed: smallest ring, single slot of capacity, full and empty edges
    write_ring_size(5'd2);
    drive_action(rdc_pkg::ACT_PUSH_BACK, 32'h0000_0005);
    drive_action(rdc_pkg::ACT_PUSH_FRONT, 32'h0000_0006);
    drive_action(rdc_pkg::ACT_PUSH_BACK, 32'h0000_0007);
    drive_action(rdc_pkg::ACT_VISIT, 32'h0);
    drive_action(rdc_pkg::ACT_POP_FRONT, 32'h0);
    drive_action(rdc_pkg::ACT_POP_FRONT, 32'h0);
    drive_action(rdc_pkg::ACT_PUSH_FRONT, 32'haaaa_aaaa);
    drive_action(rdc_pkg::ACT_SEARCH, 32'haaaa_aaaa);
    drive_action(rdc_pkg::ACT_VISIT, 32'h0);

    // random phases over several ring sizes, out-of-range sizes among them
    write_ring_size(5'd16);
    run_random(22, 90);
    calm = 1'b1;
    write_ring_size(5'd5);
    run_random(10, 70);
    calm = 1'b0;
    write_ring_size(5'd0);
    run_random(10, 70);
    write_ring_size(5'd31);
    run_random(10, 85);
    write_ring_size(5'($urandom_range(3, 15)));
    run_random(10, 75);
    write_ring_size(5'd2);
    run_random(8, 60);
    calm = 1'b1;
    write_ring_size(5'd16);
    run_random(14, 90);

    // wait out remaining results
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
